// ----- rtl/core/ppa_pkg.sv -----
// shared widths and types for the polygon perimeter and area unit
`default_nettype none

package ppa_pkg;

   // field and accumulator widths
   localparam int COORD_W = 16;
   localparam int TERM_W  = 33;
   localparam int LEN_W   = 17;
   localparam int RAD_W   = 34;
   localparam int CROSS_W = 50;
   localparam int PSUM_W  = 29;
   localparam int AREA_W  = 48;
   localparam int PERIM_W = 28;

   // one edge contribution: cross term and truncated length
   typedef struct packed {
      logic [TERM_W-1:0] term;
      logic [LEN_W-1:0]  len;
   } edge_result_type;

endpackage

`default_nettype wire

// ----- rtl/core/polygon_perimeter_area_unit.sv -----
// Polygon perimeter and area unit: vertices stream in one per item as signed
// Q12.4 coordinates; the vertex flagged last closes the polygon and yields one
// result item with |shoelace sum| (units of 1/256), the perimeter (units of
// 1/16), a three-or-more-vertices flag and a saturation flag. Every edge goes
// through one shared edge unit: a start state, a bit-serial multiply of the
// cross term and both squares, a state that forms the radicand and a 17-step
// bit-per-cycle square root. A first vertex is only stored, a later vertex
// runs its edge, a vertex dropped past the vertex limit runs none, and a last
// vertex runs its own edge and the closing edge, started back to back, before
// the result register loads; a dropped last vertex runs only the closing edge
// from the previous vertex and a lone last vertex goes straight to the load.
// Items are accepted while an earlier result still waits on the output; only
// the loading of the next result waits for it.
`default_nettype none

module polygon_perimeter_area_unit #(
   parameter int MAX_VERTICES = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [ppa_pkg::COORD_W-1:0]  req_vertex_x,
   input  wire logic signed [ppa_pkg::COORD_W-1:0]  req_vertex_y,
   input  wire logic                                req_is_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [ppa_pkg::AREA_W-1:0]               rsp_area,
   output logic [ppa_pkg::PERIM_W-1:0]              rsp_perimeter,
   output logic                                     rsp_is_polygon,
   output logic                                     rsp_saturated
);
   import ppa_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   typedef enum logic [1:0] {S_IDLE, S_EDGE, S_CLOSE, S_EMIT} top_state_type;

   top_state_type              state_ff, state_in;
   logic signed [COORD_W-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic                       cur_last_ff, cur_last_in;
   logic signed [COORD_W-1:0]  first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [COORD_W-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CROSS_W-1:0]         cross_ff, cross_in;
   logic [PSUM_W-1:0]          psum_ff, psum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0]          area_ff, area_in;
   logic [PERIM_W-1:0]         perim_ff, perim_in;
   logic                       poly_ff, poly_in;
   logic                       sat_ff, sat_in;

   logic                       accept;
   logic                       room;
   logic                       edge_start;
   logic signed [COORD_W-1:0]  edge_ax, edge_ay, edge_bx, edge_by;
   logic                       edge_done;
   edge_result_type            edge_res;
   logic [CROSS_W:0]           cross_sum;
   logic [CROSS_W-1:0]         cross_acc;
   logic [PSUM_W:0]            psum_sum;
   logic [PSUM_W-1:0]          psum_acc;
   logic [CROSS_W-1:0]         area_mag;
   logic                       area_over;
   logic                       perim_over;

   ppa_edge u_edge (
      .clock  (clock),
      .reset  (reset),
      .start  (edge_start),
      .ax     (edge_ax),
      .ay     (edge_ay),
      .bx     (edge_bx),
      .by     (edge_by),
      .done   (edge_done),
      .result (edge_res)
   );

   assign accept = req_valid && req_ready;
   assign room   = (count_ff < CNT_W'(MAX_VERTICES));

   // edge operands: from idle the previous vertex to the new one (or to the
   // first vertex when the new one is dropped), later the closing edge
   always_comb begin
      if (state_ff == S_IDLE) begin
         edge_ax = prev_x_ff;
         edge_ay = prev_y_ff;
         edge_bx = room ? req_vertex_x : first_x_ff;
         edge_by = room ? req_vertex_y : first_y_ff;
      end else begin
         edge_ax = cur_x_ff;
         edge_ay = cur_y_ff;
         edge_bx = first_x_ff;
         edge_by = first_y_ff;
      end
   end

   // saturating accumulation of one edge
   always_comb begin
      cross_sum = {cross_ff[CROSS_W-1], cross_ff}
                + {{(CROSS_W + 1 - TERM_W){edge_res.term[TERM_W-1]}}, edge_res.term};
      if (cross_sum[CROSS_W] != cross_sum[CROSS_W-1]) begin
         cross_acc = cross_sum[CROSS_W] ? {1'b1, {(CROSS_W-1){1'b0}}}
                                        : {1'b0, {(CROSS_W-1){1'b1}}};
      end else begin
         cross_acc = cross_sum[CROSS_W-1:0];
      end
      psum_sum = {1'b0, psum_ff} + (PSUM_W + 1)'(edge_res.len);
      psum_acc = psum_sum[PSUM_W] ? '1 : psum_sum[PSUM_W-1:0];
   end

   // magnitude and clipping of the finished sums
   always_comb begin
      area_mag   = cross_ff[CROSS_W-1] ? (~cross_ff + CROSS_W'(1)) : cross_ff;
      area_over  = |area_mag[CROSS_W-1:AREA_W];
      perim_over = |psum_ff[PSUM_W-1:PERIM_W];
   end

   // vertex sequencing
   always_comb begin
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_last_in  = cur_last_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      count_in     = count_ff;
      cross_in     = cross_ff;
      psum_in      = psum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      area_in      = area_ff;
      perim_in     = perim_ff;
      poly_in      = poly_ff;
      sat_in       = sat_ff;
      edge_start   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_x_in    = req_vertex_x;
               cur_y_in    = req_vertex_y;
               cur_last_in = req_is_last;
               if (count_ff == '0) begin
                  // first vertex: no edge yet, a lone vertex closes onto itself
                  first_x_in = req_vertex_x;
                  first_y_in = req_vertex_y;
                  prev_x_in  = req_vertex_x;
                  prev_y_in  = req_vertex_y;
                  count_in   = CNT_W'(1);
                  if (req_is_last) begin
                     state_in = S_EMIT;
                  end
               end else if (room) begin
                  edge_start = 1'b1;
                  state_in   = S_EDGE;
               end else if (req_is_last) begin
                  // dropped vertex still closes from the previous one
                  edge_start = 1'b1;
                  state_in   = S_CLOSE;
               end
            end
         end
         S_EDGE: begin
            if (edge_done) begin
               cross_in  = cross_acc;
               psum_in   = psum_acc;
               prev_x_in = cur_x_ff;
               prev_y_in = cur_y_ff;
               count_in  = count_ff + CNT_W'(1);
               if (cur_last_ff) begin
                  edge_start = 1'b1;
                  state_in   = S_CLOSE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CLOSE: begin
            if (edge_done) begin
               cross_in = cross_acc;
               psum_in  = psum_acc;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               area_in      = area_over ? '1 : area_mag[AREA_W-1:0];
               perim_in     = perim_over ? '1 : psum_ff[PERIM_W-1:0];
               poly_in      = (count_ff >= CNT_W'(3));
               sat_in       = area_over || perim_over;
               count_in     = '0;
               cross_in     = '0;
               psum_in      = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         count_ff     <= '0;
         cross_ff     <= '0;
         psum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         count_ff     <= count_in;
         cross_ff     <= cross_in;
         psum_ff      <= psum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_last_ff <= cur_last_in;
      area_ff     <= area_in;
      perim_ff    <= perim_in;
      poly_ff     <= poly_in;
      sat_ff      <= sat_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_area       = area_ff;
   assign rsp_perimeter  = perim_ff;
   assign rsp_is_polygon = poly_ff;
   assign rsp_saturated  = sat_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ppa_isqrt.sv -----
// bit-serial truncated integer square root, one root bit per cycle
`default_nettype none

module ppa_isqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ppa_pkg::RAD_W-1:0] radicand,
   output logic                           done,
   output logic [ppa_pkg::LEN_W-1:0]      root
);
   import ppa_pkg::*;

   localparam int REM_W   = LEN_W + 2;
   localparam int SHIFT_W = REM_W + 2;
   localparam int STEPS   = RAD_W / 2;

   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]   root_ff, root_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SHIFT_W-1:0] shifted;
   logic [SHIFT_W-1:0] trial;

   // one restoring step on the next two radicand bits
   always_comb begin
      shifted = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = REM_W'(shifted - trial);
            root_in = {root_ff[LEN_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[REM_W-1:0];
            root_in = {root_ff[LEN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ppa_edge.sv -----
// one polygon edge: serial cross term and squares, then serial square root
`default_nettype none

module ppa_edge (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [ppa_pkg::COORD_W-1:0]  ax,
   input  wire logic signed [ppa_pkg::COORD_W-1:0]  ay,
   input  wire logic signed [ppa_pkg::COORD_W-1:0]  bx,
   input  wire logic signed [ppa_pkg::COORD_W-1:0]  by,
   output logic                                     done,
   output ppa_pkg::edge_result_type                 result
);
   import ppa_pkg::*;

   localparam int PP_W = COORD_W + 2;
   localparam int HI_W = COORD_W + 3;

   typedef enum logic [1:0] {E_IDLE, E_MUL, E_SUM, E_ROOT} edge_state_type;

   edge_state_type state_ff, state_in;
   logic [3:0]               bit_ff, bit_in;
   logic signed [COORD_W-1:0] ax_ff, ax_in, bx_ff, bx_in;
   logic [COORD_W-1:0]       by_sh_ff, by_sh_in, ay_sh_ff, ay_sh_in;
   logic signed [HI_W-1:0]   cr_hi_ff, cr_hi_in;
   logic [COORD_W-1:0]       cr_lo_ff, cr_lo_in;
   logic [COORD_W-1:0]       du_ff, du_in, dv_ff, dv_in;
   logic [COORD_W-1:0]       du_sh_ff, du_sh_in, dv_sh_ff, dv_sh_in;
   logic [COORD_W-1:0]       su_hi_ff, su_hi_in, su_lo_ff, su_lo_in;
   logic [COORD_W-1:0]       sv_hi_ff, sv_hi_in, sv_lo_ff, sv_lo_in;

   logic signed [COORD_W:0]  dx, dy;
   logic signed [PP_W-1:0]   pp;
   logic signed [HI_W-1:0]   cr_sum;
   logic [COORD_W:0]         su_sum, sv_sum;
   logic                     root_start;
   logic [RAD_W-1:0]         radicand;
   logic                     root_done;
   logic [LEN_W-1:0]         root;
   logic                     load;

   // square root of dx squared plus dy squared
   ppa_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   assign radicand   = {2'b00, su_hi_ff, su_lo_ff} + {2'b00, sv_hi_ff, sv_lo_ff};
   assign root_start = (state_ff == E_SUM);

   // a new edge may start when idle or in the cycle the previous one finishes
   assign load = start && ((state_ff == E_IDLE) || ((state_ff == E_ROOT) && root_done));

   // shift-add steps of the cross product and the two squares
   always_comb begin
      dx = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
      dy = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
      pp = (by_sh_ff[0] ? PP_W'(ax_ff) : PP_W'(0)) - (ay_sh_ff[0] ? PP_W'(bx_ff) : PP_W'(0));
      // the top multiplier bit carries negative weight
      if (bit_ff == 4'd15) begin
         cr_sum = cr_hi_ff - HI_W'(pp);
      end else begin
         cr_sum = cr_hi_ff + HI_W'(pp);
      end
      su_sum = {1'b0, su_hi_ff} + (du_sh_ff[0] ? {1'b0, du_ff} : '0);
      sv_sum = {1'b0, sv_hi_ff} + (dv_sh_ff[0] ? {1'b0, dv_ff} : '0);

      state_in = state_ff;
      bit_in   = bit_ff;
      ax_in    = ax_ff;
      bx_in    = bx_ff;
      by_sh_in = by_sh_ff;
      ay_sh_in = ay_sh_ff;
      cr_hi_in = cr_hi_ff;
      cr_lo_in = cr_lo_ff;
      du_in    = du_ff;
      dv_in    = dv_ff;
      du_sh_in = du_sh_ff;
      dv_sh_in = dv_sh_ff;
      su_hi_in = su_hi_ff;
      su_lo_in = su_lo_ff;
      sv_hi_in = sv_hi_ff;
      sv_lo_in = sv_lo_ff;

      // operand load for a new edge
      if (load) begin
         ax_in    = ax;
         bx_in    = bx;
         by_sh_in = by;
         ay_sh_in = ay;
         cr_hi_in = '0;
         cr_lo_in = '0;
         du_in    = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
         dv_in    = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
         du_sh_in = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
         dv_sh_in = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
         su_hi_in = '0;
         su_lo_in = '0;
         sv_hi_in = '0;
         sv_lo_in = '0;
         bit_in   = '0;
      end

      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               state_in = E_MUL;
            end
         end
         E_MUL: begin
            by_sh_in = {1'b0, by_sh_ff[COORD_W-1:1]};
            ay_sh_in = {1'b0, ay_sh_ff[COORD_W-1:1]};
            du_sh_in = {1'b0, du_sh_ff[COORD_W-1:1]};
            dv_sh_in = {1'b0, dv_sh_ff[COORD_W-1:1]};
            cr_hi_in = cr_sum >>> 1;
            cr_lo_in = {cr_sum[0], cr_lo_ff[COORD_W-1:1]};
            su_hi_in = su_sum[COORD_W:1];
            su_lo_in = {su_sum[0], su_lo_ff[COORD_W-1:1]};
            sv_hi_in = sv_sum[COORD_W:1];
            sv_lo_in = {sv_sum[0], sv_lo_ff[COORD_W-1:1]};
            bit_in   = bit_ff + 4'd1;
            if (bit_ff == 4'd15) begin
               state_in = E_SUM;
            end
         end
         E_SUM: begin
            state_in = E_ROOT;
         end
         E_ROOT: begin
            if (root_done) begin
               state_in = start ? E_MUL : E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
      end
      ax_ff    <= ax_in;
      bx_ff    <= bx_in;
      by_sh_ff <= by_sh_in;
      ay_sh_ff <= ay_sh_in;
      cr_hi_ff <= cr_hi_in;
      cr_lo_ff <= cr_lo_in;
      du_ff    <= du_in;
      dv_ff    <= dv_in;
      du_sh_ff <= du_sh_in;
      dv_sh_ff <= dv_sh_in;
      su_hi_ff <= su_hi_in;
      su_lo_ff <= su_lo_in;
      sv_hi_ff <= sv_hi_in;
      sv_lo_ff <= sv_lo_in;
   end

   // result is taken in the cycle of done
   assign done        = (state_ff == E_ROOT) && root_done;
   assign result.term = TERM_W'({cr_hi_ff, cr_lo_ff});
   assign result.len  = root;

endmodule

`default_nettype wire
